// ===== hdl/fac_pkg.sv =====
// shared constants, codes, control structs and plane lookup functions for the frustum culler
package fac_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int ELEM_W          = 32;
	localparam int FRAC_BITS       = 16;
	localparam int PLANE_COUNT     = 6;
	localparam int PLANE_AW        = 3;
	localparam int ROW_COUNT       = 4;
	localparam int ROW_AW          = 2;
	localparam int AXES            = 3;

	localparam logic [PLANE_AW-1:0] PLANE_LAST = PLANE_AW'(PLANE_COUNT - 1);
	localparam logic [ROW_AW-1:0]   COL_W      = 2'd3;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_TEST  = 1'b1
	} op_t;

	localparam logic [1:0] CLS_INSIDE   = 2'd0;
	localparam logic [1:0] CLS_STRADDLE = 2'd1;
	localparam logic [1:0] CLS_OUTSIDE  = 2'd2;

	typedef struct packed {
		logic              rd_en;
		logic              merge;
		logic [ROW_AW-1:0] row;
		logic [ROW_AW-1:0] col;
	} fac_mcmd_t;

	typedef struct packed {
		logic                en;
		logic [PLANE_AW-1:0] plane;
		logic [ROW_AW-1:0]   lane;
	} fac_pwr_t;

	typedef struct packed {
		logic                en;
		logic                last;
		logic [PLANE_AW-1:0] plane;
	} fac_prd_t;

	typedef struct packed {
		logic valid;
		logic last;
	} fac_tag_t;

	typedef struct packed {
		logic valid;
		logic last;
		logic outside;
		logic straddle;
	} fac_flag_t;

	// matrix column that feeds each plane
	function automatic logic [ROW_AW-1:0] plane_col(input logic [PLANE_AW-1:0] k);
		logic [ROW_AW-1:0] c;
		case (k)
			3'd0, 3'd1: c = 2'd0;
			3'd2, 3'd3: c = 2'd1;
			3'd4, 3'd5: c = 2'd2;
			default:    c = 2'd0;
		endcase
		return c;
	endfunction

	// left, top and near take the negated column
	function automatic logic plane_neg(input logic [PLANE_AW-1:0] k);
		logic n;
		case (k)
			3'd0, 3'd3, 3'd4: n = 1'b1;
			default:          n = 1'b0;
		endcase
		return n;
	endfunction

endpackage

// ===== hdl/frustum_aabb_cull.sv =====
// top level: frustum plane upkeep and box classification against six stored planes
//
//   channel  dir  handshake             payload
//   input    in   in_valid / in_ready   operation, element_index, element_value, box_min_*, box_max_*
//   output   out  out_valid / out_ready classification
//
// a matrix write is one row read, one merge write, then six plane lane writes
// a box test issues six plane reads into the four-stage distance pipeline,
//   one plane per cycle, then loads the result register
// one item is in flight at a time; in_ready is high only when idle
// a result waiting on out_ready holds the block in its last step
// reset clears control state and marks all matrix rows and planes as zero
module frustum_aabb_cull import fac_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     operation,
	input  logic [3:0]               element_index,
	input  logic signed [ELEM_W-1:0] element_value,
	input  logic signed [ELEM_W-1:0] box_min_x,
	input  logic signed [ELEM_W-1:0] box_min_y,
	input  logic signed [ELEM_W-1:0] box_min_z,
	input  logic signed [ELEM_W-1:0] box_max_x,
	input  logic signed [ELEM_W-1:0] box_max_y,
	input  logic signed [ELEM_W-1:0] box_max_z,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               classification
);

	localparam int CW = COORD_WIDTH;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WR_MERGE,
		S_WR_PLANE,
		S_TEST,
		S_TEST_WAIT,
		S_RESULT
	} state_t;

	state_t                         state_q;
	logic [PLANE_AW-1:0]            k_q;
	logic                           out_any_q;
	logic                           str_any_q;
	logic                           out_valid_q;
	logic [1:0]                     cls_q;
	logic [3:0]                     idx_q;
	logic [CW-1:0]                  val_q;
	logic [1:0][AXES-1:0][CW-1:0]   box_q;
	logic [1:0][AXES-1:0][CW-1:0]   box_c;
	logic                           accept;
	fac_mcmd_t                      mcmd;
	fac_pwr_t                       pwr;
	fac_prd_t                       prd;
	fac_flag_t                      flag;
	logic [CW:0]                    comp;
	logic [ROW_COUNT-1:0]           row_valid;
	logic [ROW_COUNT*(CW+1)-1:0]    plane_rd;

	assign box_c[0][0] = CW'($unsigned(box_min_x));
	assign box_c[0][1] = CW'($unsigned(box_min_y));
	assign box_c[0][2] = CW'($unsigned(box_min_z));
	assign box_c[1][0] = CW'($unsigned(box_max_x));
	assign box_c[1][1] = CW'($unsigned(box_max_y));
	assign box_c[1][2] = CW'($unsigned(box_max_z));

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	assign mcmd.rd_en = accept && (operation == OP_WRITE);
	assign mcmd.merge = (state_q == S_WR_MERGE);
	assign mcmd.row   = (state_q == S_IDLE) ? element_index[3:2] : idx_q[3:2];
	assign mcmd.col   = idx_q[1:0];

	assign pwr.en    = (state_q == S_WR_PLANE);
	assign pwr.plane = k_q;
	assign pwr.lane  = idx_q[3:2];

	assign prd.en    = (state_q == S_TEST);
	assign prd.last  = (k_q == PLANE_LAST);
	assign prd.plane = k_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= element_index;
			val_q <= CW'($unsigned(element_value));
			box_q <= box_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			out_any_q   <= 1'b0;
			str_any_q   <= 1'b0;
			out_valid_q <= 1'b0;
			cls_q       <= CLS_INSIDE;
		end else begin
			if (out_valid_q && out_ready && state_q != S_RESULT)
				out_valid_q <= 1'b0;
			if (flag.valid) begin
				if (flag.outside)
					out_any_q <= 1'b1;
				if (flag.straddle)
					str_any_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					k_q <= '0;
					if (accept) begin
						out_any_q <= 1'b0;
						str_any_q <= 1'b0;
						state_q   <= (operation == OP_WRITE) ? S_WR_MERGE : S_TEST;
					end
				end
				S_WR_MERGE: begin
					state_q <= S_WR_PLANE;
				end
				S_WR_PLANE: begin
					if (k_q == PLANE_LAST) begin
						k_q     <= '0;
						state_q <= S_IDLE;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_TEST: begin
					if (k_q == PLANE_LAST) begin
						k_q     <= '0;
						state_q <= S_TEST_WAIT;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_TEST_WAIT: begin
					if (flag.valid && flag.last)
						state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						if (out_any_q)
							cls_q <= CLS_OUTSIDE;
						else if (str_any_q)
							cls_q <= CLS_STRADDLE;
						else
							cls_q <= CLS_INSIDE;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign classification = cls_q;

	fac_matrix #(.CW(CW)) u_matrix (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (mcmd),
		.value     (val_q),
		.plane_sel (k_q),
		.comp      (comp),
		.row_valid (row_valid)
	);

	fac_plane_store #(.CW(CW)) u_planes (
		.clk       (clk),
		.pwr       (pwr),
		.wdata     (comp),
		.prd       (prd),
		.row_valid (row_valid),
		.rdata     (plane_rd)
	);

	fac_dot #(.CW(CW)) u_dot (
		.clk    (clk),
		.arst_n (arst_n),
		.issue  (prd),
		.plane  (plane_rd),
		.box    (box_q),
		.flag   (flag)
	);

endmodule

// ===== hdl/fac_matrix.sv =====
// matrix row memory with read-merge-write and plane component derivation
module fac_matrix import fac_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fac_mcmd_t            cmd,
	input  logic [CW-1:0]        value,
	input  logic [PLANE_AW-1:0]  plane_sel,
	output logic [CW:0]          comp,
	output logic [ROW_COUNT-1:0] row_valid
);

	localparam int P  = CW + 1;
	localparam int XW = CW + 2;

	logic [ROW_COUNT*CW-1:0] mem [ROW_COUNT];
	logic [ROW_COUNT*CW-1:0] rdata_q;
	logic [ROW_COUNT*CW-1:0] row_q;
	logic [ROW_COUNT*CW-1:0] merged;
	logic [ROW_COUNT-1:0]    rowv_q;
	logic [ROW_AW-1:0]       col;
	logic signed [XW-1:0]    sel_x;
	logic signed [XW-1:0]    w_x;
	logic signed [XW-1:0]    diff;

	// a row never written reads as zero
	always_comb begin
		for (int e = 0; e < ROW_COUNT; e++) begin
			if (ROW_AW'(e) == cmd.col)
				merged[e*CW +: CW] = value;
			else if (rowv_q[cmd.row])
				merged[e*CW +: CW] = rdata_q[e*CW +: CW];
			else
				merged[e*CW +: CW] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en)
			rdata_q <= mem[cmd.row];
		if (cmd.merge) begin
			mem[cmd.row] <= merged;
			row_q        <= merged;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rowv_q <= '0;
		end else if (cmd.merge) begin
			rowv_q[cmd.row] <= 1'b1;
		end
	end

	// +/- column minus w column, saturated to the plane width
	always_comb begin
		col   = plane_col(plane_sel);
		sel_x = XW'($signed(row_q[col*CW +: CW]));
		w_x   = XW'($signed(row_q[COL_W*CW +: CW]));
		if (plane_neg(plane_sel))
			diff = -sel_x - w_x;
		else
			diff = sel_x - w_x;
		if (!diff[XW-1] && diff[XW-2])
			comp = {1'b0, {CW{1'b1}}};
		else if (diff[XW-1] && !diff[XW-2])
			comp = {1'b1, {CW{1'b0}}};
		else
			comp = diff[P-1:0];
	end

	assign row_valid = rowv_q;

endmodule

// ===== hdl/fac_plane_store.sv =====
// plane memory, one row of four components per plane, lane writes and registered reads
module fac_plane_store import fac_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF
) (
	input  logic                       clk,
	input  fac_pwr_t                   pwr,
	input  logic [CW:0]                wdata,
	input  fac_prd_t                   prd,
	input  logic [ROW_COUNT-1:0]       row_valid,
	output logic [ROW_COUNT*(CW+1)-1:0] rdata
);

	localparam int P = CW + 1;

	logic [ROW_COUNT*P-1:0] mem [PLANE_COUNT];
	logic [ROW_COUNT*P-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (pwr.en)
			mem[pwr.plane][pwr.lane*P +: P] <= wdata;
		if (prd.en)
			rd_q <= mem[prd.plane];
	end

	// component r is valid once matrix row r has been written
	for (genvar r = 0; r < ROW_COUNT; r++) begin : g_lane
		assign rdata[r*P +: P] = row_valid[r] ? rd_q[r*P +: P] : '0;
	end

endmodule

// ===== hdl/fac_dot.sv =====
// pipelined plane distance unit: near and far corner dot products and plane flags
module fac_dot import fac_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  fac_prd_t                        issue,
	input  logic [ROW_COUNT*(CW+1)-1:0]     plane,
	input  logic [1:0][AXES-1:0][CW-1:0]    box,
	output fac_flag_t                       flag
);

	localparam int P   = CW + 1;
	localparam int LW  = CW / 2;
	localparam int HW  = CW - LW;
	localparam int PLW = P + LW + 1;
	localparam int PHW = P + HW;
	localparam int PCW = P + CW;
	localparam int SW  = PCW + 2;

	fac_tag_t tag_s1, tag_s2, tag_s3, tag_s4;

	logic signed [PLW-1:0] pl_s2 [AXES][2];
	logic signed [PHW-1:0] ph_s2 [AXES][2];
	logic [AXES-1:0]       pos_s2, pos_s3;
	logic signed [P-1:0]   w_s2, w_s3;
	logic signed [PCW-1:0] prod_s3 [AXES][2];
	logic signed [SW-1:0]  dn_s4, df_s4;
	logic signed [SW-1:0]  dn_c, df_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s1 <= '{valid: issue.en, last: issue.last};
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	// coordinate split in halves, each half product registered
	always_ff @(posedge clk) begin
		for (int i = 0; i < AXES; i++) begin
			pos_s2[i] <= $signed(plane[i*P +: P]) > 0;
			for (int j = 0; j < 2; j++) begin
				pl_s2[i][j] <= PLW'($signed(plane[i*P +: P]))
					* PLW'($signed({1'b0, box[j][i][LW-1:0]}));
				ph_s2[i][j] <= PHW'($signed(plane[i*P +: P]))
					* PHW'($signed(box[j][i][CW-1:LW]));
			end
		end
		w_s2 <= $signed(plane[AXES*P +: P]);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < AXES; i++) begin
			for (int j = 0; j < 2; j++) begin
				prod_s3[i][j] <= (PCW'(ph_s2[i][j]) <<< LW) + PCW'(pl_s2[i][j]);
			end
		end
		pos_s3 <= pos_s2;
		w_s3   <= w_s2;
	end

	// nearest corner takes the minimum where the normal is positive
	always_comb begin
		dn_c = SW'(w_s3) <<< FRAC_BITS;
		df_c = SW'(w_s3) <<< FRAC_BITS;
		for (int i = 0; i < AXES; i++) begin
			dn_c = dn_c + (pos_s3[i] ? SW'(prod_s3[i][0]) : SW'(prod_s3[i][1]));
			df_c = df_c + (pos_s3[i] ? SW'(prod_s3[i][1]) : SW'(prod_s3[i][0]));
		end
	end

	always_ff @(posedge clk) begin
		dn_s4 <= dn_c;
		df_s4 <= df_c;
	end

	assign flag.valid    = tag_s4.valid;
	assign flag.last     = tag_s4.last;
	assign flag.outside  = !dn_s4[SW-1] && (dn_s4 != '0);
	assign flag.straddle = !df_s4[SW-1];

endmodule

// ===== hdl/fac_checker.sv =====
// port-level checks for the frustum culler and their binding to the top level
module fac_checker import fac_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       operation,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] classification
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(classification))
		else $error("result changed or dropped while stalled");

	a_cls_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (classification == CLS_INSIDE || classification == CLS_STRADDLE
			|| classification == CLS_OUTSIDE))
		else $error("classification code out of range");

	// one item at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in flight");

	// a matrix write produces no result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && operation == OP_WRITE |=> !$rose(out_valid))
		else $error("result appeared after a matrix write");

endmodule

bind frustum_aabb_cull fac_checker u_fac_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.operation      (operation),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.classification (classification)
);

// ===== tb/frustum_cull_checker.sv =====
// checker for the frustum culler: tracks matrix and planes, predicts box classes, compares results
`timescale 1ns / 1ps
module frustum_cull_checker import fac_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic                     operation,
	input  logic [3:0]               element_index,
	input  logic signed [ELEM_W-1:0] element_value,
	input  logic signed [ELEM_W-1:0] box_min_x,
	input  logic signed [ELEM_W-1:0] box_min_y,
	input  logic signed [ELEM_W-1:0] box_min_z,
	input  logic signed [ELEM_W-1:0] box_max_x,
	input  logic signed [ELEM_W-1:0] box_max_y,
	input  logic signed [ELEM_W-1:0] box_max_z,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic [1:0]               classification,
	output int                       errors,
	output int                       pending
);

	logic signed [ELEM_W-1:0] view_matrix [16];
	logic signed [ELEM_W:0]   frustum_plane [PLANE_COUNT][ROW_COUNT];
	logic [1:0]               expected_class_q [$];
	logic [1:0]               oldest_class;
	int                       fail_total;

	function automatic bit plane_negated(input int k);
		return (k == 0) || (k == 3) || (k == 4);
	endfunction

	function automatic void rebuild_planes();
		longint v;
		longint col_v;
		longint w_v;
		longint top_lim;
		top_lim = (longint'(1) << ELEM_W) - 1;
		for (int k = 0; k < PLANE_COUNT; k++) begin
			for (int r = 0; r < ROW_COUNT; r++) begin
				col_v = view_matrix[r * 4 + (k >> 1)];
				w_v = view_matrix[r * 4 + 3];
				v = plane_negated(k) ? -col_v - w_v : col_v - w_v;
				if (v > top_lim) v = top_lim;
				if (v < -top_lim - 1) v = -top_lim - 1;
				frustum_plane[k][r] = v[ELEM_W:0];
			end
		end
	endfunction

	// exact n . p + w, with w aligned to the product fraction
	function automatic logic signed [79:0] plane_distance(input int k, input logic [95:0] pt);
		logic signed [79:0] acc;
		logic signed [79:0] n;
		logic signed [79:0] c;
		acc = frustum_plane[k][3];
		acc = acc <<< FRAC_BITS;
		for (int i = 0; i < AXES; i++) begin
			n = frustum_plane[k][i];
			c = $signed(pt[ELEM_W * i +: ELEM_W]);
			acc = acc + n * c;
		end
		return acc;
	endfunction

	function automatic logic [1:0] classify_box(input logic [95:0] lo, input logic [95:0] hi);
		logic [95:0]        near_pt;
		logic [95:0]        far_pt;
		logic signed [79:0] dn;
		logic signed [79:0] df;
		bit                 straddle;
		straddle = 1'b0;
		for (int k = 0; k < PLANE_COUNT; k++) begin
			for (int i = 0; i < AXES; i++) begin
				if (frustum_plane[k][i] > 0) begin
					near_pt[ELEM_W * i +: ELEM_W] = lo[ELEM_W * i +: ELEM_W];
					far_pt[ELEM_W * i +: ELEM_W]  = hi[ELEM_W * i +: ELEM_W];
				end else begin
					near_pt[ELEM_W * i +: ELEM_W] = hi[ELEM_W * i +: ELEM_W];
					far_pt[ELEM_W * i +: ELEM_W]  = lo[ELEM_W * i +: ELEM_W];
				end
			end
			dn = plane_distance(k, near_pt);
			if (dn > 0) return CLS_OUTSIDE;
			df = plane_distance(k, far_pt);
			if (df >= 0) straddle = 1'b1;
		end
		return straddle ? CLS_STRADDLE : CLS_INSIDE;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) view_matrix[i] = '0;
			for (int k = 0; k < PLANE_COUNT; k++)
				for (int r = 0; r < ROW_COUNT; r++) frustum_plane[k][r] = '0;
			expected_class_q.delete();
			fail_total = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_class_q.size() == 0) begin
					$error("classification: expected none, actual %0d", classification);
					fail_total++;
				end else begin
					oldest_class = expected_class_q.pop_front();
					if (classification !== oldest_class) begin
						$error("classification: expected %0d, actual %0d",
							oldest_class, classification);
						fail_total++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (operation == OP_TEST) begin
					expected_class_q.push_back(classify_box(
						{box_min_z, box_min_y, box_min_x},
						{box_max_z, box_max_y, box_max_x}));
				end else begin
					view_matrix[element_index] = element_value;
					rebuild_planes();
				end
			end
			errors <= fail_total;
			pending <= expected_class_q.size();
		end
	end

endmodule

// ===== tb/tb_frustum_aabb_cull.sv =====
// testbench top: drives matrix writes and box tests into the frustum culler and reports the verdict
`timescale 1ns / 1ps
module tb_frustum_aabb_cull;
	import fac_pkg::*;

	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
	localparam int                 Q_ONE = 65536;
	localparam int                 STALL_LIMIT = 2000;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic                     operation;
	logic [3:0]               element_index;
	logic signed [ELEM_W-1:0] element_value;
	logic signed [ELEM_W-1:0] box_min_x;
	logic signed [ELEM_W-1:0] box_min_y;
	logic signed [ELEM_W-1:0] box_min_z;
	logic signed [ELEM_W-1:0] box_max_x;
	logic signed [ELEM_W-1:0] box_max_y;
	logic signed [ELEM_W-1:0] box_max_z;
	logic                     out_valid;
	logic                     out_ready;
	logic [1:0]               classification;

	int errors;
	int pending;
	int send_idle;
	int recv_idle;
	int item_count;
	int quiet_cycles;

	frustum_aabb_cull DUT (.*);

	frustum_cull_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [95:0] corner(input int x, input int y, input int z);
		return {z, y, x};
	endfunction

	function automatic logic [95:0] rand_corner();
		return {$urandom(), $urandom(), $urandom()};
	endfunction

	function automatic int rand_span(input int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	task automatic push_item(input op_t op, input logic [3:0] idx, input logic [31:0] val,
			input logic [95:0] lo, input logic [95:0] hi);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		operation     <= op;
		element_index <= idx;
		element_value <= val;
		box_min_x     <= lo[31:0];
		box_min_y     <= lo[63:32];
		box_min_z     <= lo[95:64];
		box_max_x     <= hi[31:0];
		box_max_y     <= hi[63:32];
		box_max_z     <= hi[95:64];
		do @(posedge clk); while (!in_ready);
		item_count++;
	endtask

	task automatic write_element(input logic [3:0] idx, input logic [31:0] val);
		push_item(OP_WRITE, idx, val, rand_corner(), rand_corner());
	endtask

	task automatic test_box(input logic [95:0] lo, input logic [95:0] hi);
		push_item(OP_TEST, 4'($urandom()), $urandom(), lo, hi);
	endtask

	// near-perspective view matrix, all sixteen elements written from a random start index
	task automatic load_view_matrix();
		int start;
		int idx;
		int r;
		int c;
		int v;
		start = $urandom_range(15);
		for (int j = 0; j < 16; j++) begin
			idx = (start + j) % 16;
			r = idx / 4;
			c = idx % 4;
			if (r == 3 && c == 3) v = $urandom_range(Q_ONE, 8 * Q_ONE);
			else if (r == 3) v = rand_span(2 * Q_ONE);
			else if (c == 3) v = rand_span(Q_ONE / 8);
			else if (r == c) begin
				v = $urandom_range(Q_ONE / 2, 2 * Q_ONE);
				if ($urandom_range(7) == 0) v = -v;
			end else if ($urandom_range(3) == 0) v = 0;
			else v = rand_span(Q_ONE / 4);
			write_element(4'(idx), v);
		end
	endtask

	task automatic probe_boxes(input int count);
		int          ctr;
		int          half;
		logic [95:0] lo;
		logic [95:0] hi;
		for (int n = 0; n < count; n++) begin
			for (int i = 0; i < AXES; i++) begin
				ctr = rand_span(8 * Q_ONE);
				half = $urandom_range(4 * Q_ONE);
				lo[32 * i +: 32] = ctr - half;
				hi[32 * i +: 32] = ctr + half;
			end
			if ($urandom_range(19) == 0) test_box(rand_corner(), rand_corner());
			else if ($urandom_range(9) == 0) test_box(hi, lo);
			else test_box(lo, hi);
		end
	endtask

	task automatic run_phase(input int s_idle, input int r_idle, input int target);
		send_idle = s_idle;
		recv_idle = r_idle;
		while (item_count < target) begin
			if ($urandom_range(99) < 85) begin
				if ($urandom_range(2) == 0) load_view_matrix();
				else write_element(4'($urandom_range(15)), rand_span(2 * Q_ONE));
				probe_boxes($urandom_range(6, 14));
			end else if ($urandom_range(1) == 0) begin
				write_element(4'($urandom_range(15)), $urandom());
			end else begin
				test_box(rand_corner(), rand_corner());
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		operation     = OP_WRITE;
		element_index = '0;
		element_value = '0;
		box_min_x     = '0;
		box_min_y     = '0;
		box_min_z     = '0;
		box_max_x     = '0;
		box_max_y     = '0;
		box_max_z     = '0;
		send_idle     = 23;
		recv_idle     = 69;
		item_count    = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// all planes zero after reset
		test_box(corner(0, 0, 0), corner(0, 0, 0));
		test_box(corner(Q_MIN, Q_MIN, Q_MIN), corner(Q_MAX, Q_MAX, Q_MAX));
		// plane components that overflow and saturate
		write_element(4'd0, Q_MIN);
		write_element(4'd3, Q_MIN);
		write_element(4'd12, Q_MIN);
		write_element(4'd15, Q_MIN);
		test_box(corner(Q_MIN, Q_MIN, Q_MIN), corner(Q_MAX, Q_MAX, Q_MAX));
		test_box(corner(Q_MAX, Q_MAX, Q_MAX), corner(Q_MIN, Q_MIN, Q_MIN));
		test_box(corner(0, 0, 0), corner(0, 0, 0));
		test_box(corner(1, 1, 1), corner(1, 1, 1));
		write_element(4'd5, Q_MAX);
		write_element(4'd10, Q_MAX);
		write_element(4'd7, Q_MIN);
		write_element(4'd11, Q_MAX);
		test_box(corner(Q_MIN, Q_MIN, Q_MIN), corner(Q_MAX, Q_MAX, Q_MAX));
		test_box(corner(-Q_ONE, -Q_ONE, -Q_ONE), corner(Q_ONE, Q_ONE, Q_ONE));
		test_box(corner(Q_MAX, Q_MIN, 0), corner(Q_MIN, Q_MAX, 0));
		test_box(corner(Q_MAX, Q_MAX, Q_MAX), corner(Q_MIN, Q_MIN, Q_MIN));
		write_element(4'd15, 4 * Q_ONE);
		write_element(4'd0, Q_ONE);
		write_element(4'd3, 0);
		write_element(4'd12, 0);
		test_box(corner(-Q_ONE, -Q_ONE, -Q_ONE), corner(Q_ONE, Q_ONE, Q_ONE));

		run_phase(23, 69, 250);
		run_phase(69, 23, 450);
		run_phase(0, 0, 640);

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== frustum_aabb_cull.f =====
hdl/fac_pkg.sv
hdl/fac_matrix.sv
hdl/fac_plane_store.sv
hdl/fac_dot.sv
hdl/frustum_aabb_cull.sv
hdl/fac_checker.sv
tb/frustum_cull_checker.sv
tb/tb_frustum_aabb_cull.sv
